FILE: hdl/cdad_pkg.sv
// Shared types, constants and helper functions for the date-add block.
// Holds the field widths, status codes, microcode word layout and program ROM.
// No dependencies.
package cdad_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int OffW    = 17;
  localparam int StatusW = 2;
  localparam int AccW    = 18;
  localparam int StepW   = 4;

  localparam logic [YearW-1:0]  YearMax  = 14'd16383;
  localparam logic [YearW-1:0]  Cycle400 = 14'd400;
  localparam logic [YearW-1:0]  Last400  = 14'd399;
  localparam logic [MonthW-1:0] MonJan   = 4'd1;
  localparam logic [MonthW-1:0] MonFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonApr   = 4'd4;
  localparam logic [MonthW-1:0] MonJun   = 4'd6;
  localparam logic [MonthW-1:0] MonSep   = 4'd9;
  localparam logic [MonthW-1:0] MonNov   = 4'd11;
  localparam logic [MonthW-1:0] MonDec   = 4'd12;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SUB400,
    OP_ADDOFF,
    OP_FWD,
    OP_BWD,
    OP_EMIT_OK,
    OP_EMIT_BAD,
    OP_EMIT_RANGE
  } op_t;

  // Flag tested by a step; when it is set the step jumps and skips its operation
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_LT400,
    C_BAD_DATE,
    C_OFF_NEG,
    C_FWD_EXIT,
    C_FWD_FIT,
    C_BWD_EXIT,
    C_D_NONPOS,
    C_OUT_BUSY
  } cond_t;

  // Where to go after the operation has run
  typedef enum logic [1:0] {
    NX_STEP,
    NX_HOLD,
    NX_IDLE
  } nxt_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    nxt_t  nxt;
    step_t tgt;
  } uword_t;

  // Program addresses
  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_MOD   = 4'd1;
  localparam step_t S_CHECK = 4'd2;
  localparam step_t S_ADD   = 4'd3;
  localparam step_t S_SIGN  = 4'd4;
  localparam step_t S_FWD   = 4'd5;
  localparam step_t S_FWDX  = 4'd6;
  localparam step_t S_RANGE = 4'd7;
  localparam step_t S_BWD   = 4'd8;
  localparam step_t S_BWDX  = 4'd9;
  localparam step_t S_OK    = 4'd10;
  localparam step_t S_BAD   = 4'd11;

  // Program ROM
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:  w = '{OP_LOAD,       C_NO_IN,    NX_STEP, S_IDLE};
      S_MOD:   w = '{OP_SUB400,     C_LT400,    NX_HOLD, S_CHECK};
      S_CHECK: w = '{OP_NOP,        C_BAD_DATE, NX_STEP, S_BAD};
      S_ADD:   w = '{OP_ADDOFF,     C_NEVER,    NX_STEP, S_IDLE};
      S_SIGN:  w = '{OP_NOP,        C_OFF_NEG,  NX_STEP, S_BWD};
      S_FWD:   w = '{OP_FWD,        C_FWD_EXIT, NX_HOLD, S_FWDX};
      S_FWDX:  w = '{OP_NOP,        C_FWD_FIT,  NX_STEP, S_OK};
      S_RANGE: w = '{OP_EMIT_RANGE, C_OUT_BUSY, NX_IDLE, S_RANGE};
      S_BWD:   w = '{OP_BWD,        C_BWD_EXIT, NX_HOLD, S_BWDX};
      S_BWDX:  w = '{OP_NOP,        C_D_NONPOS, NX_STEP, S_RANGE};
      S_OK:    w = '{OP_EMIT_OK,    C_OUT_BUSY, NX_IDLE, S_OK};
      S_BAD:   w = '{OP_EMIT_BAD,   C_OUT_BUSY, NX_IDLE, S_BAD};
      default: w = '{OP_NOP,        C_ALWAYS,   NX_STEP, S_IDLE};
    endcase
    return w;
  endfunction

  // Leap rule from the two low year bits and the year modulo 400
  function automatic logic is_leap(logic [1:0] y_lo, logic [YearW-1:0] r400);
    return (y_lo == 2'd0) && (r400 != 14'd100) && (r400 != 14'd200) &&
           (r400 != 14'd300);
  endfunction

  // Month length in days
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) begin
      len = 5'd30;
    end else if (m == MonFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

FILE: hdl/cdad_if.sv
// Valid/ready channel interfaces for the date-add block.
// Depends on cdad_pkg for field widths.
interface cdad_in_if;
  logic                           valid;
  logic                           ready;
  logic [cdad_pkg::YearW-1:0]     start_year;
  logic [cdad_pkg::MonthW-1:0]    start_month;
  logic [cdad_pkg::DayW-1:0]      start_day;
  logic signed [cdad_pkg::OffW-1:0] day_offset;

  modport source (output valid, start_year, start_month, start_day, day_offset,
                  input ready);
  modport sink (input valid, start_year, start_month, start_day, day_offset,
                output ready);
endinterface

interface cdad_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdad_pkg::YearW-1:0]    result_year;
  logic [cdad_pkg::MonthW-1:0]   result_month;
  logic [cdad_pkg::DayW-1:0]     result_day;
  logic [cdad_pkg::StatusW-1:0]  status;

  modport source (output valid, result_year, result_month, result_day, status,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, status,
                output ready);
endinterface

FILE: hdl/calendar_date_add_days.sv
// Steps: load, reduce the year modulo 400 by repeated subtraction, check the start date
// (a bad date goes straight to its emit step), add the offset, test its sign, walk month
// by month with exit steps, and emit into the output register, waiting while it is full.
// Throughput: one beat at a time; the next beat is taken the cycle after the result
// is written, while that result may still wait in the output register.
// Reset (rst, synchronous) returns the step counter to idle and empties the output.
module calendar_date_add_days (
  input logic          clk,
  input logic          rst,
  cdad_in_if.sink      start,
  cdad_out_if.source   result
);

  cdad_pkg::step_t  pc;
  cdad_pkg::step_t  pc_next;
  cdad_pkg::uword_t uw;

  logic [cdad_pkg::YearW-1:0]        y;
  logic [cdad_pkg::MonthW-1:0]       m;
  logic signed [cdad_pkg::AccW-1:0]  d;
  logic signed [cdad_pkg::OffW-1:0]  off;
  logic [cdad_pkg::YearW-1:0]        r400;

  logic                              leap;
  logic [cdad_pkg::DayW-1:0]         mlen;
  logic [cdad_pkg::DayW-1:0]         mlen_prev;
  logic signed [cdad_pkg::AccW-1:0]  mlen_s;
  logic signed [cdad_pkg::AccW-1:0]  mlen_prev_s;
  logic                              d_fits;
  logic                              out_busy;
  logic                              flag;
  logic                              exec;

  logic                              out_valid;
  logic [cdad_pkg::YearW-1:0]        out_year;
  logic [cdad_pkg::MonthW-1:0]       out_month;
  logic [cdad_pkg::DayW-1:0]         out_day;
  cdad_pkg::status_t                 out_status;

  // Fetch the control word of the current step
  assign uw = cdad_pkg::ucode(pc);

  // Month lengths for the current year
  assign leap        = cdad_pkg::is_leap(y[1:0], r400);
  assign mlen        = cdad_pkg::month_len(m, leap);
  assign mlen_prev   = cdad_pkg::month_len(m - 4'd1, leap);
  assign mlen_s      = $signed({{(cdad_pkg::AccW-cdad_pkg::DayW){1'b0}}, mlen});
  assign mlen_prev_s = $signed({{(cdad_pkg::AccW-cdad_pkg::DayW){1'b0}}, mlen_prev});
  assign d_fits      = (d <= mlen_s);
  assign out_busy    = out_valid && !result.ready;

  // Select the tested flag
  always_comb begin
    unique case (uw.cond)
      cdad_pkg::C_NEVER:    flag = 1'b0;
      cdad_pkg::C_ALWAYS:   flag = 1'b1;
      cdad_pkg::C_NO_IN:    flag = !start.valid;
      cdad_pkg::C_LT400:    flag = (r400 < cdad_pkg::Cycle400);
      cdad_pkg::C_BAD_DATE: flag = (m == 4'd0) || (m > cdad_pkg::MonDec) ||
                                   (d == '0) || !d_fits;
      cdad_pkg::C_OFF_NEG:  flag = off[cdad_pkg::OffW-1];
      cdad_pkg::C_FWD_EXIT: flag = d_fits ||
                                   ((m == cdad_pkg::MonDec) && (y == cdad_pkg::YearMax));
      cdad_pkg::C_FWD_FIT:  flag = d_fits;
      cdad_pkg::C_BWD_EXIT: flag = (d > 0) || ((m == cdad_pkg::MonJan) && (y == '0));
      cdad_pkg::C_D_NONPOS: flag = (d <= 0);
      cdad_pkg::C_OUT_BUSY: flag = out_busy;
      default:              flag = 1'b1;
    endcase
  end

  assign exec = !flag;

  // Sequence: jump on flag, else run the operation and step, hold or return to idle
  always_comb begin
    if (flag) begin
      pc_next = uw.tgt;
    end else begin
      unique case (uw.nxt)
        cdad_pkg::NX_STEP: pc_next = pc + 4'd1;
        cdad_pkg::NX_HOLD: pc_next = pc;
        cdad_pkg::NX_IDLE: pc_next = cdad_pkg::S_IDLE;
        default:           pc_next = cdad_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cdad_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign start.ready = (pc == cdad_pkg::S_IDLE);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uw.op)
        cdad_pkg::OP_LOAD: begin
          y    <= start.start_year;
          m    <= start.start_month;
          d    <= $signed({{(cdad_pkg::AccW-cdad_pkg::DayW){1'b0}}, start.start_day});
          off  <= start.day_offset;
          r400 <= start.start_year;
        end
        cdad_pkg::OP_SUB400: begin
          r400 <= r400 - cdad_pkg::Cycle400;
        end
        cdad_pkg::OP_ADDOFF: begin
          d <= d + cdad_pkg::AccW'(off);
        end
        cdad_pkg::OP_FWD: begin
          // Leave the current month, wrapping into the next year after December
          d <= d - mlen_s;
          if (m == cdad_pkg::MonDec) begin
            m    <= cdad_pkg::MonJan;
            y    <= y + 14'd1;
            r400 <= (r400 == cdad_pkg::Last400) ? '0 : r400 + 14'd1;
          end else begin
            m <= m + 4'd1;
          end
        end
        cdad_pkg::OP_BWD: begin
          // Step back one month, wrapping into December of the previous year
          if (m == cdad_pkg::MonJan) begin
            m    <= cdad_pkg::MonDec;
            y    <= y - 14'd1;
            d    <= d + 18'sd31;
            r400 <= (r400 == '0) ? cdad_pkg::Last400 : r400 - 14'd1;
          end else begin
            m <= m - 4'd1;
            d <= d + mlen_prev_s;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: fill on an emit step, drain on ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && (uw.op == cdad_pkg::OP_EMIT_OK || uw.op == cdad_pkg::OP_EMIT_BAD ||
                          uw.op == cdad_pkg::OP_EMIT_RANGE)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uw.op)
        cdad_pkg::OP_EMIT_OK,
        cdad_pkg::OP_EMIT_BAD: begin
          out_year   <= y;
          out_month  <= m;
          out_day    <= d[cdad_pkg::DayW-1:0];
          out_status <= (uw.op == cdad_pkg::OP_EMIT_OK) ? cdad_pkg::ST_OK
                                                         : cdad_pkg::ST_BAD_DATE;
        end
        cdad_pkg::OP_EMIT_RANGE: begin
          out_year   <= '0;
          out_month  <= '0;
          out_day    <= '0;
          out_status <= cdad_pkg::ST_RANGE;
        end
        default: begin
        end
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.result_year  = out_year;
  assign result.result_month = out_month;
  assign result.result_day   = out_day;
  assign result.status       = out_status;

`ifndef SYNTHESIS
  // A new result only appears after one of the emit steps
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == cdad_pkg::S_OK || $past(pc) == cdad_pkg::S_BAD ||
                          $past(pc) == cdad_pkg::S_RANGE))
    else $error("result raised outside an emit step");

  // The year residue is reduced before the date is checked or walked
  assert property (@(posedge clk) disable iff (rst)
    (pc != cdad_pkg::S_IDLE && pc != cdad_pkg::S_MOD) |-> (r400 < cdad_pkg::Cycle400))
    else $error("year residue not reduced below 400");

  // A good result carries a real month and day
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == cdad_pkg::ST_OK) |->
      (out_month >= cdad_pkg::MonJan && out_month <= cdad_pkg::MonDec && out_day != '0))
    else $error("ok result with impossible month or day");

  // An out-of-range result has all date fields cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == cdad_pkg::ST_RANGE) |->
      (out_year == '0 && out_month == '0 && out_day == '0))
    else $error("range result with nonzero date");
`endif

endmodule
